>>> design/emp_pkg.sv
package emp_pkg;

    localparam int ENTRIES     = 256;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int MARK_W      = ($clog2(ENTRIES + 1) > 9) ? $clog2(ENTRIES + 1) : 9;
    localparam int COLOUR_W    = 24;
    localparam int CH_W        = 8;
    localparam int IDX_W       = 8;
    localparam int FIRST_W     = 8;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 2;

    localparam logic [FIRST_W-1:0] FIRST_RESET = FIRST_W'(16);
    localparam logic [MARK_W-1:0]  ENTRIES_M   = MARK_W'(ENTRIES);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             is_new;
        logic             full_res;
    } t_rsp;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] data;
    } t_tbl_wr;

endpackage

>>> design/exact_match_palette_builder.sv
// Exact-match palette builder. A request (start high while busy is low) carries one 24-bit
// colour; the block scans the palette from first_entry up to the fill mark, one stored entry
// per cycle through the table read port, and answers with one result strobe on o_done.
// A miss is answered once every entry from first_entry up to the fill mark has been compared,
// a hit as soon as the matching entry has been compared. On a miss the colour is stored at
// the fill mark and flagged new; with no free entry left the result has full_res set and
// index 0. The result is shown for exactly one cycle and cannot be stalled: capture it when
// o_done is high. Writing first_entry over APB also moves the fill mark there; table contents
// need no clearing after reset.
module exact_match_palette_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  emp_pkg::t_req                 i_req,
    output logic                          o_done,
    output emp_pkg::t_rsp                 o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [emp_pkg::PADDR_W-1:0]   paddr,
    input  logic [emp_pkg::DATA_W-1:0]    pwdata,
    output logic [emp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [emp_pkg::FIRST_W-1:0]     r_first;
    logic [emp_pkg::MARK_W-1:0]      r_fill, n_fill;
    logic [emp_pkg::MARK_W-1:0]      r_ptr, n_ptr;
    logic [emp_pkg::MARK_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                            r_cmp_vld, n_cmp_vld;
    logic [emp_pkg::COLOUR_W-1:0]    r_colour, n_colour;
    logic                            r_done, n_done;
    emp_pkg::t_rsp                   r_rsp, n_rsp;

    emp_pkg::t_tbl_wr                tbl_wr;
    logic [emp_pkg::COLOUR_W-1:0]    tbl_rdata;
    logic                            cfg_wr;
    logic                            scan_more;
    logic                            hit;

    emp_table u_table (
        .i_clk   (i_clk),
        .i_wr    (tbl_wr),
        .i_raddr (r_ptr[emp_pkg::ADDR_W-1:0]),
        .o_rdata (tbl_rdata)
    );

    assign cfg_wr    = psel && penable && pwrite;
    assign scan_more = (r_ptr < r_fill) && (r_ptr < emp_pkg::ENTRIES_M);
    assign hit       = r_cmp_vld && (tbl_rdata == r_colour);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = 1'b0;
        n_colour  = r_colour;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        tbl_wr    = '{en: 1'b0, addr: r_fill[emp_pkg::ADDR_W-1:0], data: r_colour};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_colour = {i_req.red, i_req.green, i_req.blue};
                    n_ptr    = emp_pkg::MARK_W'(r_first);
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (hit) begin
                    n_rsp   = '{index: emp_pkg::IDX_W'(r_cmp_idx), is_new: 1'b0,
                                full_res: 1'b0};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (scan_more) begin
                    // read in flight, compared next cycle
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_ptr;
                    n_ptr     = r_ptr + 1'b1;
                end else if (!r_cmp_vld) begin
                    if (r_fill >= emp_pkg::ENTRIES_M) begin
                        n_rsp = '{index: '0, is_new: 1'b0, full_res: 1'b1};
                    end else begin
                        tbl_wr.en = 1'b1;
                        n_rsp  = '{index: emp_pkg::IDX_W'(r_fill), is_new: 1'b1,
                                   full_res: 1'b0};
                        n_fill = r_fill + 1'b1;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // last compare missed, decide next cycle
                    n_cmp_vld = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_first   <= emp_pkg::FIRST_RESET;
            r_fill    <= emp_pkg::MARK_W'(emp_pkg::FIRST_RESET);
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_done    <= n_done;
            if (cfg_wr) begin
                r_first <= pwdata[emp_pkg::FIRST_W-1:0];
                r_fill  <= emp_pkg::MARK_W'(pwdata[emp_pkg::FIRST_W-1:0]);
            end else begin
                r_fill  <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_cmp_idx <= n_cmp_idx;
        r_colour  <= n_colour;
        r_rsp     <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
    assign prdata = emp_pkg::DATA_W'(r_first);
    assign pready = 1'b1;

endmodule

>>> design/emp_table.sv
module emp_table (
    input  logic                          i_clk,
    input  emp_pkg::t_tbl_wr              i_wr,
    input  logic [emp_pkg::ADDR_W-1:0]    i_raddr,
    output logic [emp_pkg::COLOUR_W-1:0]  o_rdata
);

    logic [emp_pkg::COLOUR_W-1:0] r_mem [emp_pkg::ENTRIES];
    logic [emp_pkg::COLOUR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/emp_checker.sv
module emp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_done,
    input  emp_pkg::t_rsp                 o_rsp,
    input  logic                          pready
);

    // an accepted request keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // result only shows when the block is idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // a request that ends (busy falls) shows a result strobe
    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("request finished without result");

    // full result carries index zero and is never new
    a_full_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.full_res |-> (o_rsp.index == '0) && !o_rsp.is_new)
        else $error("bad full result");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind exact_match_palette_builder emp_checker u_emp_checker (.*);

>>> tb/palette_index_monitor.sv
module palette_index_monitor #(
    parameter logic [emp_pkg::PADDR_W-1:0] FIRST_ENTRY_ADDR = '0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  emp_pkg::t_req                 i_req,
    input  logic                          i_done,
    input  emp_pkg::t_rsp                 i_rsp,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [emp_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [emp_pkg::DATA_W-1:0]    i_pwdata,
    input  logic [emp_pkg::DATA_W-1:0]    i_prdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    import emp_pkg::*;

    logic [COLOUR_W-1:0] palette [ENTRIES];
    logic [MARK_W-1:0]   fill_mark = MARK_W'(FIRST_RESET);
    logic [FIRST_W-1:0]  base_entry = FIRST_RESET;
    t_rsp                owed_results[$];
    int                  mismatches = 0;

    function automatic t_rsp lookup_colour(t_req c);
        t_rsp                r;
        logic [COLOUR_W-1:0] key;
        int                  k;
        key = {c.red, c.green, c.blue};
        r = '0;
        for (k = int'(base_entry); k < int'(fill_mark) && k < ENTRIES; k++) begin
            if (palette[k] == key) begin
                r.index = IDX_W'(k);
                return r;
            end
        end
        // no free entry left: full flag, nothing stored
        if (fill_mark >= ENTRIES_M) begin
            r.full_res = 1'b1;
            return r;
        end
        palette[fill_mark[ADDR_W-1:0]] = key;
        r.index = fill_mark[IDX_W-1:0];
        r.is_new = 1'b1;
        fill_mark = fill_mark + 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            base_entry = FIRST_RESET;
            fill_mark = MARK_W'(FIRST_RESET);
            owed_results.delete();
        end else begin
            if (i_done) begin
                if (owed_results.size() == 0) begin
                    $error("result with no request outstanding: index %0d", i_rsp.index);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_rsp.index !== want.index) begin
                        $error("index mismatch: expected %0d, actual %0d",
                               want.index, i_rsp.index);
                        mismatches++;
                    end
                    if (i_rsp.is_new !== want.is_new) begin
                        $error("is_new mismatch: expected %0b, actual %0b",
                               want.is_new, i_rsp.is_new);
                        mismatches++;
                    end
                    if (i_rsp.full_res !== want.full_res) begin
                        $error("full_res mismatch: expected %0b, actual %0b",
                               want.full_res, i_rsp.full_res);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                owed_results.push_back(lookup_colour(i_req));
            end
            if (i_psel && i_penable && i_pready && i_paddr == FIRST_ENTRY_ADDR) begin
                if (i_pwrite) begin
                    base_entry = i_pwdata[FIRST_W-1:0];
                    fill_mark = MARK_W'(base_entry);
                end else if (i_prdata !== DATA_W'(base_entry)) begin
                    $error("first_entry mismatch: expected %0d, actual %0d",
                           base_entry, i_prdata);
                    mismatches++;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending <= owed_results.size();
    end

endmodule

>>> tb/exact_match_palette_builder_tb.sv
module exact_match_palette_builder_tb;
    import emp_pkg::*;

    localparam logic [PADDR_W-1:0] FIRST_ENTRY_ADDR = '0;
    localparam int RANDOM_ITEMS = 850;
    localparam int CALM_ITEMS   = 100;
    localparam int DRAIN_CYCLES = ENTRIES + 4;
    localparam int STALL_LIMIT  = 8 * (ENTRIES + 8);

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    t_req               i_req   = '0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;

    logic               busy;
    logic               o_done;
    t_rsp               o_rsp;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;
    int                 stall_cycles = 0;
    int                 sent = 0;
    t_req               recent[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    exact_match_palette_builder DUT (.*);

    palette_index_monitor #(.FIRST_ENTRY_ADDR(FIRST_ENTRY_ADDR)) u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("exact_match_palette_builder regression: fail");
            $finish;
        end
    end

    task automatic send_colour(t_req c);
        i_req = c;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        recent.push_back(c);
    endtask

    task automatic gap(int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [FIRST_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = FIRST_ENTRY_ADDR;
        pwdata = DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_first_entry(logic [FIRST_W-1:0] value);
        drain();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        recent.delete();
    endtask

    function automatic t_req pick_colour(int fresh_pct);
        logic [COLOUR_W-1:0] raw;
        if (recent.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
            raw = COLOUR_W'($urandom);
        end else begin
            raw = recent[$urandom_range(0, recent.size() - 1)];
            // near miss: one bit off a colour already seen
            if ($urandom_range(0, 9) == 0) begin
                raw[$urandom_range(0, COLOUR_W - 1)] ^= 1'b1;
            end
        end
        return raw;
    endfunction

    initial begin
        logic [COLOUR_W-1:0] warmup [10];
        logic [FIRST_W-1:0]  first_sel;
        int                  n_items;
        int                  fresh_pct;
        int                  idle_pct;
        int                  phase;
        int                  k;

        warmup = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00,
                   24'h0000FF, 24'hFFFFFF, 24'h0000FF, 24'h000001, 24'h800000};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_access(1'b0, '0);
        for (k = 0; k < 10; k++) begin
            send_colour(warmup[k]);
        end

        // one usable entry, then full
        set_first_entry(8'd255);
        send_colour(t_req'(24'h123456));
        send_colour(t_req'(24'h123456));
        send_colour(t_req'(24'h123457));
        send_colour(t_req'(24'h123456));

        // moving the fill mark down overwrites the old entry
        set_first_entry(8'd254);
        send_colour(t_req'(24'h123457));
        send_colour(t_req'(24'h123456));
        send_colour(t_req'(24'hFEDCBA));
        send_colour(t_req'(24'h123457));

        set_first_entry(8'd0);
        send_colour(t_req'(24'h000000));
        send_colour(t_req'(24'hFFFFFF));
        send_colour(t_req'(24'h000000));

        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: first_sel = 8'd0;
                1: first_sel = 8'd255;
                default: begin
                    case ($urandom_range(0, 4))
                        0: first_sel = FIRST_W'($urandom_range(0, 255));
                        1: first_sel = FIRST_W'($urandom_range(192, 254));
                        2: first_sel = FIRST_RESET;
                        3: first_sel = FIRST_W'($urandom_range(1, 63));
                        default: first_sel = $urandom_range(0, 1) ? 8'd0 : 8'd255;
                    endcase
                end
            endcase
            set_first_entry(first_sel);
            n_items = $urandom_range(30, 160);
            fresh_pct = $urandom_range(15, 90);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            for (k = 0; k < n_items && sent < RANDOM_ITEMS; k++) begin
                if (sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < idle_pct) begin
                    gap($urandom_range(1, 5));
                end
                send_colour(pick_colour(fresh_pct));
                sent++;
            end
            phase++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("exact_match_palette_builder regression: pass");
        end else begin
            $display("exact_match_palette_builder regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
design/emp_pkg.sv
design/emp_table.sv
design/exact_match_palette_builder.sv
design/emp_checker.sv
tb/palette_index_monitor.sv
tb/exact_match_palette_builder_tb.sv
